// ===== rtl/sha256_pkg.sv =====
// Package for the SHA-256 engine: round constants, initial hash values and round functions.
`timescale 1ns / 1ps

package sha256_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned NumRounds = 64;
   localparam int unsigned NumChain  = 8;
   localparam int unsigned BlockBits = 512;
   localparam int unsigned LenPos    = 56;

   localparam logic [7:0] PadByte  = 8'h80;
   localparam logic [7:0] ZeroByte = 8'h00;

   typedef logic [WordWidth-1:0] word_type;

   localparam word_type ROUND_K [NumRounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type INIT_H [NumChain] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (WordWidth - n));
   endfunction

   function automatic word_type big_s0(input word_type x);
      big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_s1(input word_type x);
      big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type lil_s0(input word_type x);
      lil_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type lil_s1(input word_type x);
      lil_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

// ===== rtl/sha256_hash_engine_top.sv =====
// SHA-256 engine: byte gather, padding sequencer, shared round unit and digest output.
// A byte that does not fill a block is taken in idle; a byte that fills a block starts
// the 64 rounds in the one round unit, then the feed-forward step, before input resumes.
// Finish: padding bytes go in one per cycle up to the block end; each padded block (one or two)
// then takes the rounds and feed-forward, then 8 digest transfers at one per cycle when rsp_tready is high.
// The single round unit runs 64 rounds per 64-byte block; no byte is taken while it works.
// Reset (synchronous, active high) loads the initial hash values and clears count and fill.
`timescale 1ns / 1ps

module sha256_hash_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] kind (0 byte, 1 finish)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
   output logic        rsp_tlast
);

   import sha256_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FEED,
      ST_ROUND,
      ST_FFWD,
      ST_OUT
   } state_type;

   state_type      state_ff, state_in;
   word_type       chain_ff [NumChain];
   word_type       chain_in [NumChain];
   word_type       var_ff   [NumChain];
   word_type       var_in   [NumChain];
   logic [BlockBits-1:0] blk_ff, blk_in;
   logic [5:0]     fill_ff, fill_in;
   logic [5:0]     rnd_ff, rnd_in;
   logic [63:0]    len_ff, len_in;
   logic           first_ff, first_in;   // next pad byte is the 0x80 marker
   logic           tail_ok_ff, tail_ok_in;  // length fits in the current block
   logic           pad_ff, pad_in;       // finishing a message
   logic [2:0]     idx_ff, idx_in;

   logic           req_xfer, rsp_xfer;
   logic [63:0]    len_bits;
   logic [2:0]     len_sel;
   logic [7:0]     len_byte, pad_byte;
   word_type       w_cur, w_new, t1, t2, ch, maj;
   word_type       a, b, c, d, e, f, g, h;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // Outputs
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {5'b00000, idx_ff, chain_ff[idx_ff]};
   assign rsp_tlast  = (idx_ff == 3'(NumChain - 1));

   // Length field bytes, most significant first
   assign len_bits = {len_ff[60:0], 3'b000};
   assign len_sel  = ~fill_ff[2:0];
   assign len_byte = len_bits[{len_sel, 3'b000} +: 8];

   always_comb begin
      if (first_ff) begin
         pad_byte = PadByte;
      end else if (tail_ok_ff && (fill_ff >= 6'(LenPos))) begin
         pad_byte = len_byte;
      end else begin
         pad_byte = ZeroByte;
      end
   end

   // Round unit; the block register doubles as the 16-word schedule window
   assign a = var_ff[0];
   assign b = var_ff[1];
   assign c = var_ff[2];
   assign d = var_ff[3];
   assign e = var_ff[4];
   assign f = var_ff[5];
   assign g = var_ff[6];
   assign h = var_ff[7];

   assign w_cur = blk_ff[511:480];
   assign w_new = lil_s1(blk_ff[63:32]) + blk_ff[223:192] + lil_s0(blk_ff[479:448]) + w_cur;
   assign ch    = (e & f) ^ (~e & g);
   assign maj   = (a & b) ^ (a & c) ^ (b & c);
   assign t1    = h + big_s1(e) + ch + ROUND_K[rnd_ff] + w_cur;
   assign t2    = big_s0(a) + maj;

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      chain_in   = chain_ff;
      var_in     = var_ff;
      blk_in     = blk_ff;
      fill_in    = fill_ff;
      rnd_in     = rnd_ff;
      len_in     = len_ff;
      first_in   = first_ff;
      tail_ok_in = tail_ok_ff;
      pad_in     = pad_ff;
      idx_in     = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_tuser) begin
                  state_in = ST_FEED;
                  first_in = 1'b1;
                  pad_in   = 1'b1;
               end else begin
                  blk_in  = {blk_ff[BlockBits-9:0], req_tdata};
                  fill_in = fill_ff + 6'd1;
                  len_in  = len_ff + 64'd1;
                  if (fill_ff == 6'd63) begin
                     var_in   = chain_ff;
                     rnd_in   = '0;
                     state_in = ST_ROUND;
                  end
               end
            end
         end

         ST_FEED: begin
            blk_in   = {blk_ff[BlockBits-9:0], pad_byte};
            fill_in  = fill_ff + 6'd1;
            first_in = 1'b0;
            if (first_ff) begin
               tail_ok_in = (fill_ff < 6'(LenPos));
            end
            if (fill_ff == 6'd63) begin
               var_in   = chain_ff;
               rnd_in   = '0;
               state_in = ST_ROUND;
            end
         end

         ST_ROUND: begin
            var_in[7] = g;
            var_in[6] = f;
            var_in[5] = e;
            var_in[4] = d + t1;
            var_in[3] = c;
            var_in[2] = b;
            var_in[1] = a;
            var_in[0] = t1 + t2;
            blk_in    = {blk_ff[BlockBits-33:0], w_new};
            rnd_in    = rnd_ff + 6'd1;
            if (rnd_ff == 6'(NumRounds - 1)) begin
               state_in = ST_FFWD;
            end
         end

         ST_FFWD: begin
            for (int i = 0; i < NumChain; i++) begin
               chain_in[i] = chain_ff[i] + var_ff[i];
            end
            if (!pad_ff) begin
               state_in = ST_IDLE;
            end else if (tail_ok_ff) begin
               idx_in   = '0;
               state_in = ST_OUT;
            end else begin
               tail_ok_in = 1'b1;
               state_in   = ST_FEED;
            end
         end

         ST_OUT: begin
            if (rsp_xfer) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'(NumChain - 1)) begin
                  chain_in   = INIT_H;
                  len_in     = '0;
                  fill_in    = '0;
                  pad_in     = 1'b0;
                  tail_ok_in = 1'b0;
                  first_in   = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered values
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         chain_ff   <= INIT_H;
         fill_ff    <= '0;
         len_ff     <= '0;
         first_ff   <= 1'b0;
         tail_ok_ff <= 1'b0;
         pad_ff     <= 1'b0;
         idx_ff     <= '0;
         rnd_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         chain_ff   <= chain_in;
         fill_ff    <= fill_in;
         len_ff     <= len_in;
         first_ff   <= first_in;
         tail_ok_ff <= tail_ok_in;
         pad_ff     <= pad_in;
         idx_ff     <= idx_in;
         rnd_ff     <= rnd_in;
      end
      var_ff <= var_in;
      blk_ff <= blk_in;
   end

endmodule

// ===== rtl/sha256_checker.sv =====
// Port-level checks for the SHA-256 engine, bound to the top level.
`timescale 1ns / 1ps

module sha256_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // Input is never taken while a digest is being sent
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> !req_tready)
      else $error("input ready while digest pending");

   // The last marker sits on word index seven only
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[34:32] == 3'd7)))
      else $error("last marker and word index disagree");

   // After the last word the engine returns to taking input
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (!rsp_tvalid && req_tready))
      else $error("engine not idle after digest");

   // A stalled digest word holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled digest word changed");

endmodule

bind sha256_hash_engine_top sha256_checker u_sha256_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== test/testbench.sv =====
// Testbench for the SHA-256 hash engine: random-gapped stream driver, digest predictor, monitor.
`timescale 1ns / 1ps

module testbench;

   localparam int IDLE_LIMIT   = 4000;  // cycles without any transfer before giving up
   localparam int DRAIN_CYCLES = 200;   // two padded blocks plus the padding walk
   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, stalls the engine
   localparam int RAND_ITEMS   = 260;
   localparam int BLOCK_BYTES  = 64;
   localparam int LEN_AT       = 56;
   localparam logic [7:0] PAD_MARK = 8'h80;

   typedef enum logic {
      KIND_BYTE   = 1'b0,
      KIND_FINISH = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    data;
   } hash_item_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_beat_type;

   localparam logic [31:0] K_TAB [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] IV_TAB [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // DUT ports
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        req_tuser  = 1'b0;    // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;            // [31:0] digest_word, [34:32] word_index, [39:35] zero
   logic        rsp_tlast;

   // stimulus and expectations
   hash_item_type   send_q [$];
   digest_beat_type digest_expect_q [$];

   // message lengths at the padding edges
   int len_pick [3] = '{55, 56, 64};

   // predictor state
   logic [31:0] hash_state [8];
   logic [7:0]  block_buf [64];
   int          buf_fill;
   logic [63:0] byte_count;

   // handshake bookkeeping
   logic req_took = 1'b0;
   logic rsp_took = 1'b0;
   int   req_gap = 0;
   int   rsp_stall = 0;
   int   hold_left = 0;
   bit   hold_done = 1'b0;
   bit   req_quiet = 1'b0;
   bit   rsp_quiet = 1'b0;
   int   idle_cycles = 0;

   // run statistics
   int items_taken = 0;
   int messages_done = 0;
   int bytes_done = 0;
   int two_block_pads = 0;
   int words_checked = 0;
   int mismatch_count = 0;

   sha256_hash_engine_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] ep0(input logic [31:0] x);
      return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
   endfunction

   function automatic logic [31:0] ep1(input logic [31:0] x);
      return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
   endfunction

   function automatic logic [31:0] sg0(input logic [31:0] x);
      return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] sg1(input logic [31:0] x);
      return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
   endfunction

   task automatic restart_hash();
      for (int k = 0; k < 8; k++) hash_state[k] = IV_TAB[k];
      buf_fill   = 0;
      byte_count = '0;
   endtask

   // One compression over block_buf, full 64-word schedule expanded up front
   task automatic compress_buffer();
      logic [31:0] sched [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int j = 0; j < 16; j++)
         sched[j] = {block_buf[4*j], block_buf[4*j+1], block_buf[4*j+2], block_buf[4*j+3]};
      for (int j = 16; j < 64; j++)
         sched[j] = sg1(sched[j-2]) + sched[j-7] + sg0(sched[j-15]) + sched[j-16];
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int j = 0; j < 64; j++) begin
         t1 = h + ep1(e) + ((e & f) ^ (~e & g)) + K_TAB[j] + sched[j];
         t2 = ep0(a) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endtask

   // Apply one accepted item; a finish queues the eight digest words
   task automatic sha_predict_item(input hash_item_type item);
      logic [63:0]     bit_len;
      digest_beat_type beat;
      if (item.kind == KIND_BYTE) begin
         block_buf[buf_fill] = item.data;
         buf_fill   = (buf_fill + 1) % BLOCK_BYTES;
         byte_count = byte_count + 1;
         bytes_done++;
         if (buf_fill == 0) compress_buffer();
      end else begin
         bit_len = byte_count << 3;
         block_buf[buf_fill] = PAD_MARK;
         buf_fill++;
         // no room left for the length: close this block and pad a second one
         if (buf_fill > LEN_AT) begin
            while (buf_fill < BLOCK_BYTES) begin
               block_buf[buf_fill] = 8'h00;
               buf_fill++;
            end
            compress_buffer();
            buf_fill = 0;
            two_block_pads++;
         end
         while (buf_fill < LEN_AT) begin
            block_buf[buf_fill] = 8'h00;
            buf_fill++;
         end
         for (int k = 0; k < 8; k++) block_buf[LEN_AT + k] = bit_len[63 - 8*k -: 8];
         compress_buffer();
         for (int k = 0; k < 8; k++) begin
            beat.word  = hash_state[k];
            beat.index = 3'(k);
            beat.last  = (k == 7);
            digest_expect_q.push_back(beat);
         end
         messages_done++;
         restart_hash();
      end
   endtask

   // ---------------------------------------------------------------- stimulus helpers

   task automatic queue_byte(input logic [7:0] value);
      hash_item_type item;
      item.kind = KIND_BYTE;
      item.data = value;
      send_q.push_back(item);
   endtask

   task automatic queue_finish(input logic [7:0] junk);
      hash_item_type item;
      item.kind = KIND_FINISH;
      item.data = junk;
      send_q.push_back(item);
   endtask

   task automatic queue_random_message(input int len);
      for (int k = 0; k < len; k++) queue_byte(8'($urandom_range(0, 255)));
      queue_finish(8'($urandom_range(0, 255)));
   endtask

   // mostly short gaps, a few long ones, none while in a quiet stretch
   function automatic int pick_gap(input bit quiet);
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 70);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("[%0t] mismatch: %s got %h want %h", $realtime, what, got, want);
   endtask

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin
      hash_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_took)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (send_q.size() > 0) begin
            nxt = send_q.pop_front();
            req_tuser  <= nxt.kind;
            req_tdata  <= nxt.data;
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 39) == 0) req_quiet = !req_quiet;
            req_gap = pick_gap(req_quiet);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver ready

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && rsp_tvalid && items_taken > 30) begin
         // one long hold-off while the sender keeps offering bytes
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_took) begin
            if ($urandom_range(0, 39) == 0) rsp_quiet = !rsp_quiet;
            rsp_stall = pick_gap(rsp_quiet);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- monitor and watchdog

   always @(posedge clock) begin
      digest_beat_type want;
      hash_item_type   got_item;
      req_took <= req_tvalid && req_tready && !reset;
      rsp_took <= rsp_tvalid && rsp_tready && !reset;
      if (!reset) begin
         // output transfer against the oldest expected digest word
         if (rsp_tvalid && rsp_tready) begin
            if (digest_expect_q.size() == 0) begin
               report_mismatch("unexpected digest word", rsp_tdata[31:0], 32'h0);
            end else begin
               want = digest_expect_q.pop_front();
               words_checked++;
               if (rsp_tdata[31:0] !== want.word)
                  report_mismatch("digest_word", rsp_tdata[31:0], want.word);
               if (rsp_tdata[34:32] !== want.index)
                  report_mismatch("word_index", 32'(rsp_tdata[34:32]), 32'(want.index));
               if (rsp_tlast !== want.last)
                  report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
               if (rsp_tdata[39:35] !== 5'b0)
                  report_mismatch("tdata fill bits", 32'(rsp_tdata[39:35]), 32'h0);
            end
         end
         // input transfer into the predictor
         if (req_tvalid && req_tready) begin
            got_item.kind = item_kind_type'(req_tuser);
            got_item.data = req_tdata;
            sha_predict_item(got_item);
            items_taken++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("[%0t] no transfer for %0d cycles", $realtime, IDLE_LIMIT);
               $display("FAILED: results differ");
               $finish;
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int rand_items;
      int len;
      restart_hash();

      // directed: empty message, "abc", byte extremes, finish data ignored
      queue_finish(8'h00);
      queue_byte(8'h61); queue_byte(8'h62); queue_byte(8'h63);
      queue_finish(8'h00);
      queue_byte(8'h00); queue_byte(8'hff); queue_byte(8'h80); queue_byte(8'h7f);
      queue_byte(8'h01);
      queue_finish(8'hff);
      queue_finish(8'haa);

      // random: padding boundaries (length fits, spills, exact block), then a mix
      rand_items = 0;
      foreach (len_pick[i]) begin
         queue_random_message(len_pick[i]);
         rand_items += len_pick[i] + 1;
      end
      while (rand_items < RAND_ITEMS) begin
         if ($urandom_range(0, 9) == 0) len = $urandom_range(60, 70);
         else len = $urandom_range(0, 12);
         queue_random_message(len);
         rand_items += len + 1;
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (send_q.size() > 0 || req_tvalid) @(posedge clock);
      while (digest_expect_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d messages, %0d message bytes, %0d needing a second pad block.",
               messages_done, bytes_done, two_block_pads);
      $display("Checked %0d digest words, %0d mismatches.", words_checked, mismatch_count);
      if (mismatch_count == 0 && digest_expect_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
